@@ src/mdc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multiply/divide register block package
// Shared widths, register offsets, access codes, controller states and the
// command/status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package mdc_pkg;

  // Field and register widths.
  localparam int unsigned OfsW   = 7;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned OpW    = 32;
  localparam int unsigned ProdW  = 2 * OpW;
  localparam int unsigned InTdW  = 16;

  // Divider sequencing: one quotient bit per cycle.
  localparam int unsigned DivSteps = OpW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  // Register offsets inside the window.
  localparam logic [OfsW-1:0] OFS_STATUS = 7'h0F;
  localparam logic [OfsW-1:0] OFS_REM    = 7'h68;
  localparam logic [OfsW-1:0] OFS_QUO    = 7'h6C;
  localparam logic [OfsW-1:0] OFS_OPA    = 7'h70;
  localparam logic [OfsW-1:0] OFS_OPB    = 7'h74;
  localparam logic [OfsW-1:0] OFS_PROD   = 7'h78;

  // Status bits kept on an operand write (the two busy bits are cleared).
  localparam logic [ByteW-1:0] BUSY_KEEP = 8'h3F;

  // Quotient reported for a zero divisor.
  localparam logic [OpW-1:0] DIV0_QUOTIENT = '1;

  // Access kind carried on tuser.
  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_DIV
  } ctl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // Accept the access beat: update registers, latch read data.
    logic start;  // Form the product and seed the divider.
    logic step;   // Run one divider iteration.
    logic last;   // Final iteration: commit quotient and remainder.
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic op_write;  // The offered beat writes an operand byte.
  } dp_status_t;

endpackage

@@ src/mdc_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multiply/divide datapath
// Holds the operand, result and status registers, the read mux, the product
// register and a restoring radix-2 divider that resolves one bit per cycle.
// ----------------------------------------------------------------------------
module mdc_datapath
  import mdc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ctl_cmd_t         cmd_i,
  input  logic             action_i,
  input  logic [OfsW-1:0]  address_offset_i,
  input  logic [ByteW-1:0] write_data_i,
  output dp_status_t       status_o,
  output logic [ByteW-1:0] read_data_o
);

  logic [OpW-1:0]   op_a_q, op_b_q;
  logic [ProdW-1:0] product_q;
  logic [OpW-1:0]   quotient_q, remainder_q;
  logic [ByteW-1:0] status_q;
  logic [OpW-1:0]   div_rem_q, div_quo_q;
  logic [ByteW-1:0] out_data_q;

  logic             is_opa, is_opb;
  logic [ByteW-1:0] rd_byte;
  logic [ProdW-1:0] prod_c;
  logic [OpW:0]     div_shift, div_diff;
  logic [OpW-1:0]   rem_n, quo_n;
  logic             b_zero;

  // Address decode of the offered beat.
  assign is_opa = (address_offset_i >= OFS_OPA) && (address_offset_i < OFS_OPB);
  assign is_opb = (address_offset_i >= OFS_OPB) && (address_offset_i < OFS_PROD);
  assign status_o.op_write = (action_i == ACT_WRITE) && (is_opa || is_opb);

  // Read mux over the register window.
  always_comb begin
    rd_byte = '0;
    priority if (address_offset_i == OFS_STATUS) begin
      rd_byte = status_q;
    end else if (address_offset_i >= OFS_PROD) begin
      rd_byte = product_q[address_offset_i[2:0]*ByteW +: ByteW];
    end else if (address_offset_i >= OFS_OPB) begin
      rd_byte = op_b_q[address_offset_i[1:0]*ByteW +: ByteW];
    end else if (address_offset_i >= OFS_OPA) begin
      rd_byte = op_a_q[address_offset_i[1:0]*ByteW +: ByteW];
    end else if (address_offset_i >= OFS_QUO) begin
      rd_byte = quotient_q[address_offset_i[1:0]*ByteW +: ByteW];
    end else if (address_offset_i >= OFS_REM) begin
      rd_byte = remainder_q[address_offset_i[1:0]*ByteW +: ByteW];
    end else begin
      rd_byte = '0;
    end
  end

  // Single 32x32 multiply, registered into the product.
  assign prod_c = ProdW'(op_a_q) * ProdW'(op_b_q);

  // One restoring division step: shift in the next dividend bit, try to subtract.
  assign div_shift = {div_rem_q, div_quo_q[OpW-1]};
  assign div_diff  = div_shift - {1'b0, op_b_q};
  always_comb begin
    if (!div_diff[OpW]) begin
      rem_n = div_diff[OpW-1:0];
      quo_n = {div_quo_q[OpW-2:0], 1'b1};
    end else begin
      rem_n = div_shift[OpW-1:0];
      quo_n = {div_quo_q[OpW-2:0], 1'b0};
    end
  end

  assign b_zero = (op_b_q == '0);

  // Bus-visible registers and the response byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_a_q     <= '0;
      op_b_q     <= '0;
      status_q   <= '0;
      out_data_q <= '0;
    end else if (cmd_i.load) begin
      if (action_i == ACT_WRITE) begin
        out_data_q <= '0;
        if (address_offset_i == OFS_STATUS) begin
          status_q <= write_data_i;
        end else if (is_opa) begin
          op_a_q[address_offset_i[1:0]*ByteW +: ByteW] <= write_data_i;
          status_q <= status_q & BUSY_KEEP;
        end else if (is_opb) begin
          op_b_q[address_offset_i[1:0]*ByteW +: ByteW] <= write_data_i;
          status_q <= status_q & BUSY_KEEP;
        end
      end else begin
        out_data_q <= rd_byte;
      end
    end
  end

  // Product, divider working registers and committed results.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      product_q   <= '0;
      quotient_q  <= '0;
      remainder_q <= '0;
      div_rem_q   <= '0;
      div_quo_q   <= '0;
    end else if (cmd_i.start) begin
      product_q <= prod_c;
      div_rem_q <= '0;
      div_quo_q <= op_a_q;
    end else if (cmd_i.step) begin
      div_rem_q <= rem_n;
      div_quo_q <= quo_n;
      if (cmd_i.last) begin
        // A zero divisor reports all ones and hands back the dividend.
        quotient_q  <= b_zero ? DIV0_QUOTIENT : quo_n;
        remainder_q <= b_zero ? op_a_q : rem_n;
      end
    end
  end

  assign read_data_o = out_data_q;

endmodule

@@ src/mdc_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multiply/divide controller
// Handshakes the access and response beats and sequences the product and the
// bit-serial divide after every operand write.
// ----------------------------------------------------------------------------
module mdc_controller
  import mdc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output ctl_cmd_t   cmd_o
);

  ctl_state_e         state_q, state_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  logic               accept, cnt_last;

  assign in_ready_o  = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign cnt_last    = (cnt_q == DivCntW'(DivSteps - 1));
  assign out_valid_o = out_valid_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept && status_i.op_write) state_d = ST_START;
      ST_START: state_d = ST_DIV;
      ST_DIV:   if (cnt_last) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Datapath commands and counters.
  always_comb begin
    cmd_o       = '0;
    cmd_o.load  = accept;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (accept) begin
      out_valid_d = 1'b1;
    end
    unique case (state_q)
      ST_IDLE:  cnt_d = '0;
      ST_START: cmd_o.start = 1'b1;
      ST_DIV: begin
        cmd_o.step = 1'b1;
        cmd_o.last = cnt_last;
        cnt_d      = cnt_q + 1'b1;
      end
      default:  cnt_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ src/mul_div_coprocessor_registers_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multiply/divide coprocessor register block
// Byte-wide register window of an unsigned 32-bit multiply/divide unit.
// ----------------------------------------------------------------------------
// Each access beat (tuser: 0 read, 1 write) returns one response beat with the
// byte read, or zero for a write. A read, a status write or a write to any
// other offset is answered in the next cycle and the block is ready again at once.
// Writing an operand byte is answered in the next cycle as well, but the block
// then takes no new access while it recomputes: the start state forms the 64-bit
// product in a single multiplier, and the restoring divider then resolves one
// quotient bit per cycle for all 32 bits. A new access is taken while a response
// still waits, as long as that response is taken in the same cycle.
// ----------------------------------------------------------------------------
module mul_div_coprocessor_registers_unit
  import mdc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [InTdW-1:0] s_axis_tdata_i,   // [6:0] address_offset, [14:7] write_data
  input  logic             s_axis_tuser_i,   // [0] action
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [ByteW-1:0] m_axis_tdata_o    // [7:0] read_data
);

  ctl_cmd_t   cmd;
  dp_status_t dp_status;

  mdc_controller u_ctl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .status_i    (dp_status),
    .cmd_o       (cmd)
  );

  mdc_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .action_i         (s_axis_tuser_i),
    .address_offset_i (s_axis_tdata_i[OfsW-1:0]),
    .write_data_i     (s_axis_tdata_i[OfsW +: ByteW]),
    .status_o         (dp_status),
    .read_data_o      (m_axis_tdata_o)
  );

  // Every accepted access produces a response beat in the next cycle.
  a_resp_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> m_axis_tvalid_o)
    else $error("response beat missing after an accepted access");

  // An operand write blocks new accesses while the results are recomputed.
  a_busy_after_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i
      && (s_axis_tdata_i[6:3] == 4'hE) |=> !s_axis_tready_o)
    else $error("access taken during recompute");

  // Unmapped offsets read as zero; checked here for offset 0x00.
  a_unmapped_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && !s_axis_tuser_i
      && (s_axis_tdata_i[6:0] == 7'h00) |=> m_axis_tdata_o == 8'h00)
    else $error("unmapped offset returned nonzero data");

endmodule
